[rtl/owbm_pkg.sv]
// owbm_pkg: shared types and constants for the 1-wire bus master unit
// beat payload structs, command codes, register map and register reset values
// no dependencies
`timescale 1ns / 1ps

package owbm_pkg;

	localparam int CFG_W           = 12;
	localparam int NUM_CFG         = 8;
	localparam int CFG_IDX_W       = $clog2(NUM_CFG);
	localparam int BYTE_W          = 8;
	localparam int BIT_IDX_W       = $clog2(BYTE_W);
	localparam int TIMER_WIDTH_DEF = 12;

	// command codes
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESET_HIGH    = 3'd0,
		CFG_RESET_LOW     = 3'd1,
		CFG_PRESENCE_WAIT = 3'd2,
		CFG_WRITE_LOW     = 3'd3,
		CFG_WRITE_HOLD    = 3'd4,
		CFG_READ_LOW      = 3'd5,
		CFG_READ_SAMPLE   = 3'd6,
		CFG_READ_RECOVER  = 3'd7
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] RST_RESET_HIGH    = 12'd1700;
	localparam logic [CFG_W-1:0] RST_RESET_LOW     = 12'd1700;
	localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 12'd165;
	localparam logic [CFG_W-1:0] RST_WRITE_LOW     = 12'd10;
	localparam logic [CFG_W-1:0] RST_WRITE_HOLD    = 12'd315;
	localparam logic [CFG_W-1:0] RST_READ_LOW      = 12'd45;
	localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 12'd20;
	localparam logic [CFG_W-1:0] RST_READ_RECOVER  = 12'd198;

	typedef struct packed {
		logic [CFG_W-1:0] reset_high_ticks;
		logic [CFG_W-1:0] reset_low_ticks;
		logic [CFG_W-1:0] presence_wait_ticks;
		logic [CFG_W-1:0] write_low_ticks;
		logic [CFG_W-1:0] write_hold_ticks;
		logic [CFG_W-1:0] read_low_ticks;
		logic [CFG_W-1:0] read_sample_ticks;
		logic [CFG_W-1:0] read_recover_ticks;
	} cfg_regs_t;

	typedef struct packed {
		logic              tick;
		op_t               op;
		logic [BYTE_W-1:0] write_byte;
		logic              line_in;
	} owbm_in_t;

	typedef struct packed {
		logic              line_out;
		logic              busy_res;
		logic              done_res;
		logic              presence;
		logic [BYTE_W-1:0] read_byte;
	} owbm_out_t;

endpackage

[rtl/one_wire_bus_master_unit.sv]
// one_wire_bus_master_unit: 1-wire bus master pin sequencer, top level
// instantiates owbm_cfg and owbm_seq, registers the result beat; uses owbm_pkg
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_wen              | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready  | in_data  (owbm_in_t)
//  out     | out       | out_valid / out_ready| out_data (owbm_out_t)
//
// one beat in gives one beat out in the following cycle, from the result register
// the sequencer steps on every accepted input beat; a new beat is taken each
// cycle while the result register is empty or being drained
// in_ready drops only while a result waits and out_ready is low
// arst_n puts all registers but the result data register back to their reset values at once
`timescale 1ns / 1ps

module one_wire_bus_master_unit #(
	parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [owbm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  owbm_pkg::owbm_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output owbm_pkg::owbm_out_t            out_data
);
	import owbm_pkg::*;

	cfg_regs_t regs;
	owbm_out_t result;
	owbm_out_t out_q;
	logic      out_valid_q;
	logic      step;

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	owbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	owbm_seq #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_beat (in_data),
		.regs    (regs),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/owbm_cfg.sv]
// owbm_cfg: slot timing register bank, written through a plain write port
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [owbm_pkg::CFG_W-1:0]     cfg_data,
	output owbm_pkg::cfg_regs_t            regs
);
	import owbm_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_high_ticks    <= RST_RESET_HIGH;
			regs_q.reset_low_ticks     <= RST_RESET_LOW;
			regs_q.presence_wait_ticks <= RST_PRESENCE_WAIT;
			regs_q.write_low_ticks     <= RST_WRITE_LOW;
			regs_q.write_hold_ticks    <= RST_WRITE_HOLD;
			regs_q.read_low_ticks      <= RST_READ_LOW;
			regs_q.read_sample_ticks   <= RST_READ_SAMPLE;
			regs_q.read_recover_ticks  <= RST_READ_RECOVER;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RESET_HIGH:    regs_q.reset_high_ticks    <= cfg_data;
				CFG_RESET_LOW:     regs_q.reset_low_ticks     <= cfg_data;
				CFG_PRESENCE_WAIT: regs_q.presence_wait_ticks <= cfg_data;
				CFG_WRITE_LOW:     regs_q.write_low_ticks     <= cfg_data;
				CFG_WRITE_HOLD:    regs_q.write_hold_ticks    <= cfg_data;
				CFG_READ_LOW:      regs_q.read_low_ticks      <= cfg_data;
				CFG_READ_SAMPLE:   regs_q.read_sample_ticks   <= cfg_data;
				CFG_READ_RECOVER:  regs_q.read_recover_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

[rtl/owbm_seq.sv]
// owbm_seq: pin sequencer state, slot timer and next-state logic
// advances once per accepted beat and presents the result of that beat
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_seq #(
	parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  owbm_pkg::owbm_in_t  in_beat,
	input  owbm_pkg::cfg_regs_t regs,
	output owbm_pkg::owbm_out_t result
);
	import owbm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_RST_HIGH   = 4'd1,
		PH_RST_LOW    = 4'd2,
		PH_RST_WAIT   = 4'd3,
		PH_WR_LOW     = 4'd4,
		PH_WR_HOLD    = 4'd5,
		PH_RD_LOW     = 4'd6,
		PH_RD_WAIT    = 4'd7,
		PH_RD_RECOVER = 4'd8
	} phase_t;

	localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BYTE_W - 1);

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic [BIT_IDX_W-1:0]   bit_q, bit_d;
	logic [BYTE_W-1:0]      shift_q, shift_d;
	logic                   pres_q, pres_d;
	logic                   line_q, line_d;
	logic [BYTE_W-1:0]      rdata_q, rdata_d;
	logic                   done_d;

	logic [CFG_W-1:0]       lim_raw;
	logic [TIMER_WIDTH-1:0] lim;
	logic [TIMER_WIDTH-1:0] timer_run;
	logic                   over;

	// tick count of the current phase
	always_comb begin
		unique case (phase_q)
			PH_RST_HIGH:   lim_raw = regs.reset_high_ticks;
			PH_RST_LOW:    lim_raw = regs.reset_low_ticks;
			PH_RST_WAIT:   lim_raw = regs.presence_wait_ticks;
			PH_WR_LOW:     lim_raw = regs.write_low_ticks;
			PH_WR_HOLD:    lim_raw = regs.write_hold_ticks;
			PH_RD_LOW:     lim_raw = regs.read_low_ticks;
			PH_RD_WAIT:    lim_raw = regs.read_sample_ticks;
			PH_RD_RECOVER: lim_raw = regs.read_recover_ticks;
			default:       lim_raw = '0;
		endcase
	end

	// saturate the count when the timer is narrower than a register
	generate
		if (TIMER_WIDTH >= CFG_W) begin : g_wide
			assign lim = TIMER_WIDTH'(lim_raw);
		end else begin : g_narrow
			assign lim = (lim_raw[CFG_W-1:TIMER_WIDTH] != '0) ? '1 : lim_raw[TIMER_WIDTH-1:0];
		end
	endgenerate

	assign over      = (timer_q >= lim);
	assign timer_run = over ? '0 :
		((in_beat.tick && timer_q != '1) ? timer_q + 1'b1 : timer_q);

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_run;
		bit_d   = bit_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		line_d  = line_q;
		rdata_d = rdata_q;
		done_d  = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				timer_d = '0;
				unique case (in_beat.op)
					OP_RESET: begin
						line_d  = 1'b1;
						phase_d = PH_RST_HIGH;
					end
					OP_WRITE: begin
						shift_d = in_beat.write_byte;
						bit_d   = '0;
						line_d  = 1'b0;
						phase_d = PH_WR_LOW;
					end
					OP_READ: begin
						shift_d = '0;
						bit_d   = '0;
						line_d  = 1'b0;
						phase_d = PH_RD_LOW;
					end
					default: ;
				endcase
			end
			PH_RST_HIGH: if (over) begin
				line_d  = 1'b0;
				phase_d = PH_RST_LOW;
			end
			PH_RST_LOW: if (over) begin
				line_d  = 1'b1;
				phase_d = PH_RST_WAIT;
			end
			PH_RST_WAIT: if (over) begin
				// a slave pulling the line low answers the reset
				pres_d  = ~in_beat.line_in;
				phase_d = PH_IDLE;
				done_d  = 1'b1;
			end
			PH_WR_LOW: if (over) begin
				line_d  = shift_q[0];
				phase_d = PH_WR_HOLD;
			end
			PH_WR_HOLD: if (over) begin
				shift_d = shift_q >> 1;
				if (bit_q == BIT_LAST) begin
					line_d  = 1'b1;
					bit_d   = '0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end else begin
					line_d  = 1'b0;
					bit_d   = bit_q + 1'b1;
					phase_d = PH_WR_LOW;
				end
			end
			PH_RD_LOW: if (over) begin
				line_d  = 1'b1;
				phase_d = PH_RD_WAIT;
			end
			PH_RD_WAIT: if (over) begin
				shift_d = {in_beat.line_in, shift_q[BYTE_W-1:1]};
				phase_d = PH_RD_RECOVER;
			end
			PH_RD_RECOVER: if (over) begin
				if (bit_q == BIT_LAST) begin
					bit_d   = '0;
					rdata_d = shift_q;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end else begin
					bit_d   = bit_q + 1'b1;
					line_d  = 1'b0;
					phase_d = PH_RD_LOW;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				timer_d = '0;
				line_d  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			line_q  <= 1'b1;
			rdata_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			line_q  <= line_d;
			rdata_q <= rdata_d;
		end
	end

	assign result.line_out  = line_d;
	assign result.busy_res  = (phase_d != PH_IDLE);
	assign result.done_res  = done_d;
	assign result.presence  = pres_d;
	assign result.read_byte = rdata_d;

endmodule

[rtl/owbm_checker.sv]
// owbm_checker: port-level checks for one_wire_bus_master_unit, bound to the top
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input owbm_pkg::owbm_out_t out_data
);
	import owbm_pkg::*;

	// a waiting result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// an empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// every accepted input beat shows up as a result beat next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted beat gave no result beat");

	// completion goes with a return to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done while still busy");

	// the line is released whenever no command runs
	a_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.busy_res |-> out_data.line_out)
		else $error("line driven low while idle");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
